// ===== hw/rtl/rgb_to_hsl_convert_unit_defines.svh =====
// ----------------------------------------------------------------------------
// rgb_to_hsl_convert_unit_defines.svh
// Assertion macros shared by the RGB to HSL checker.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSL_CONVERT_UNIT_DEFINES_SVH
`define RGB_TO_HSL_CONVERT_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is held
`define RHC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is held
`define RHC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg
// Types, widths and constants of the RGB to HSL converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int COMP_W   = 8;   // one color component
    localparam int HUE_W    = 15;
    localparam int SAT_W    = 16;
    localparam int SUM_W    = 9;
    localparam int IN_W     = 24;  // red, green, blue
    localparam int OUT_W    = 40;  // hue, saturation, lightness_sum
    localparam int QUO_W    = 16;  // divider quotient
    localparam int DEN_W    = 9;   // divider divisor and remainder
    localparam int DIV_BITS = 4;   // quotient bits per divider stage
    localparam int DIV_STG  = QUO_W / DIV_BITS;

    localparam logic [HUE_W-1:0] HUE_LIMIT  = 15'd23040; // 360 deg in 1/64 deg
    localparam logic [SUM_W-1:0] SUM_WHITE  = 9'd510;
    localparam logic [SUM_W-1:0] SUM_MID    = 9'd255;
    localparam logic [14:0]      HUE_GREEN  = 15'd7680;
    localparam logic [14:0]      HUE_BLUE   = 15'd15360;
    localparam logic [17:0]      SAT_SCALE2 = 18'd131070; // 2 * 65535

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // one restoring-division lane in flight
    typedef struct packed {
        logic [DEN_W-1:0] rem;  // partial remainder
        logic [QUO_W-1:0] lo;   // dividend bits not yet consumed, MSB first
        logic [QUO_W-1:0] quo;  // quotient bits so far
    } t_div_st;

    // DIV_BITS steps of restoring division
    function automatic t_div_st div_step(input t_div_st s, input logic [DEN_W-1:0] den);
        t_div_st          o;
        logic [DEN_W:0]   t;
        o = s;
        for (int i = 0; i < DIV_BITS; i++) begin
            t    = {o.rem, o.lo[QUO_W-1]};
            o.lo = {o.lo[QUO_W-2:0], 1'b0};
            if (t >= {1'b0, den}) begin
                t     = t - {1'b0, den};
                o.quo = {o.quo[QUO_W-2:0], 1'b1};
            end else begin
                o.quo = {o.quo[QUO_W-2:0], 1'b0};
            end
            o.rem = t[DEN_W-1:0];
        end
        return o;
    endfunction

endpackage

// ===== hw/rtl/rgb_to_hsl_convert_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsl_convert_unit
// Pipelined RGB888 to hue / saturation / lightness-sum converter.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one beat per pixel, tdata = {blue, green, red},
//   red in the low byte. Output stream (m_axis): one beat per pixel in the
//   same order, tdata = {lightness_sum[8:0], saturation[15:0], hue[14:0]}.
//   hue is in 1/64 degree (0..23039), saturation is 0..65535 for 0..1.0,
//   lightness_sum is max+min (0..510). Grey pixels give hue = sat = 0.
// Timing:
//   Six register stages: min/max and sector pick, numerator build, then four
//   restoring-divider stages that each retire 4 quotient bits of both the
//   hue and the saturation quotient (the last one is the output register).
//   Output valid rises once the beat has been registered in every stage in
//   turn; throughput is one pixel per clock while the receiver does not
//   stall, set by the divider being fully unrolled across stages.
// Reset / stall:
//   Synchronous active-low reset clears every stage valid; payload is not
//   reset. Each stage has its own ready, so a stalled receiver fills the
//   bubbles first; input tready drops only once every stage holds a beat.
//   No beat is lost or duplicated under any stall pattern.
// ----------------------------------------------------------------------------
module rgb_to_hsl_convert_unit
    import rhc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [IN_W-1:0]   i_s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [OUT_W-1:0]  o_m_axis_tdata    // hue[14:0], sat[30:15], sum[39:31]
);

    // ---------------- stage 1: max / min / sector ----------------
    logic [COMP_W-1:0] red, green, blue, mx, mn;
    t_sector           n_s1_sec;
    logic signed [8:0] n_s1_diff;

    logic              r_s1_vld;
    t_sector           r_s1_sec;
    logic signed [8:0] r_s1_diff;
    logic [COMP_W-1:0] r_s1_chroma;
    logic [SUM_W-1:0]  r_s1_sum;

    logic rdy_s1, rdy_s2;
    logic [DIV_STG-1:0] rdy_dv;

    assign red   = i_s_axis_tdata[7:0];
    assign green = i_s_axis_tdata[15:8];
    assign blue  = i_s_axis_tdata[23:16];

    always_comb begin
        mx = red;
        mn = red;
        if (green > mx) mx = green;
        if (blue  > mx) mx = blue;
        if (green < mn) mn = green;
        if (blue  < mn) mn = blue;
        // red wins ties, then green
        if (mx == red) begin
            n_s1_sec  = SEC_RED;
            n_s1_diff = $signed({1'b0, green}) - $signed({1'b0, blue});
        end else if (mx == green) begin
            n_s1_sec  = SEC_GREEN;
            n_s1_diff = $signed({1'b0, blue}) - $signed({1'b0, red});
        end else begin
            n_s1_sec  = SEC_BLUE;
            n_s1_diff = $signed({1'b0, red}) - $signed({1'b0, green});
        end
    end

    assign rdy_s1          = !r_s1_vld || rdy_s2;
    assign o_s_axis_tready = rdy_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (rdy_s1) begin
            r_s1_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_s1) begin
            r_s1_sec    <= n_s1_sec;
            r_s1_diff   <= n_s1_diff;
            r_s1_chroma <= mx - mn;
            r_s1_sum    <= {1'b0, mx} + {1'b0, mn};
        end
    end

    // ---------------- stage 2: dividends and divisors ----------------
    // hue  = floor((2N + c) / 2c), N = 3840*diff + base*c (wrapped)
    // sat  = floor((2*65535*c + d) / 2d), d = 255 - |sum - 255|
    logic signed [24:0] hue_n;
    logic signed [24:0] hue_base;
    logic [23:0]        hue_num;
    logic [24:0]        sat_num;
    logic [COMP_W-1:0]  sat_d;
    logic               grey;
    t_div_st            n_s2_h, n_s2_s;
    logic [DEN_W-1:0]   n_s2_den_h, n_s2_den_s;

    logic               r_s2_vld;
    t_div_st            r_s2_h, r_s2_s;
    logic [DEN_W-1:0]   r_s2_den_h, r_s2_den_s;
    logic [SUM_W-1:0]   r_s2_sum;

    always_comb begin
        grey = (r_s1_chroma == '0);
        case (r_s1_sec)
            SEC_RED:   hue_base = r_s1_diff[8]
                                  ? $signed({10'd0, HUE_LIMIT} * {17'd0, r_s1_chroma})
                                  : 25'sd0;
            SEC_GREEN: hue_base = $signed({10'd0, HUE_GREEN} * {17'd0, r_s1_chroma});
            SEC_BLUE:  hue_base = $signed({10'd0, HUE_BLUE} * {17'd0, r_s1_chroma});
            default:   hue_base = 25'sd0;
        endcase
        // 3840*diff = diff*4096 - diff*256
        hue_n   = ($signed({{16{r_s1_diff[8]}}, r_s1_diff}) <<< 12)
                - ($signed({{16{r_s1_diff[8]}}, r_s1_diff}) <<< 8)
                + hue_base;
        hue_num = {hue_n[22:0], 1'b0} + {16'd0, r_s1_chroma};

        sat_d   = (r_s1_sum <= SUM_MID) ? r_s1_sum[7:0] : 8'(SUM_WHITE - r_s1_sum);
        sat_num = 25'({7'd0, SAT_SCALE2} * {17'd0, r_s1_chroma}) + {17'd0, sat_d};

        n_s2_h.rem = grey ? '0 : {1'b0, hue_num[23:16]};
        n_s2_h.lo  = grey ? '0 : hue_num[15:0];
        n_s2_h.quo = '0;
        n_s2_s.rem = grey ? '0 : sat_num[24:16];
        n_s2_s.lo  = grey ? '0 : sat_num[15:0];
        n_s2_s.quo = '0;
        n_s2_den_h = grey ? DEN_W'(2) : {r_s1_chroma, 1'b0};
        n_s2_den_s = grey ? DEN_W'(2) : {sat_d, 1'b0};
    end

    assign rdy_s2 = !r_s2_vld || rdy_dv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (rdy_s2) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_s2) begin
            r_s2_h     <= n_s2_h;
            r_s2_s     <= n_s2_s;
            r_s2_den_h <= n_s2_den_h;
            r_s2_den_s <= n_s2_den_s;
            r_s2_sum   <= r_s1_sum;
        end
    end

    // ---------------- stages 3..6: divider ----------------
    logic             r_dv_vld   [DIV_STG];
    t_div_st          r_dv_h     [DIV_STG];
    t_div_st          r_dv_s     [DIV_STG];
    logic [DEN_W-1:0] r_dv_den_h [DIV_STG];
    logic [DEN_W-1:0] r_dv_den_s [DIV_STG];
    logic [SUM_W-1:0] r_dv_sum   [DIV_STG];

    for (genvar k = 0; k < DIV_STG; k++) begin : g_div
        logic             up_vld;
        t_div_st          up_h, up_s;
        logic [DEN_W-1:0] up_den_h, up_den_s;
        logic [SUM_W-1:0] up_sum;
        logic             dn_rdy;

        if (k == 0) begin : g_first
            assign up_vld   = r_s2_vld;
            assign up_h     = r_s2_h;
            assign up_s     = r_s2_s;
            assign up_den_h = r_s2_den_h;
            assign up_den_s = r_s2_den_s;
            assign up_sum   = r_s2_sum;
        end else begin : g_next
            assign up_vld   = r_dv_vld[k-1];
            assign up_h     = r_dv_h[k-1];
            assign up_s     = r_dv_s[k-1];
            assign up_den_h = r_dv_den_h[k-1];
            assign up_den_s = r_dv_den_s[k-1];
            assign up_sum   = r_dv_sum[k-1];
        end

        if (k == DIV_STG-1) begin : g_last
            assign dn_rdy = i_m_axis_tready;
        end else begin : g_mid
            assign dn_rdy = rdy_dv[k+1];
        end

        assign rdy_dv[k] = !r_dv_vld[k] || dn_rdy;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k] <= 1'b0;
            end else if (rdy_dv[k]) begin
                r_dv_vld[k] <= up_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy_dv[k]) begin
                r_dv_h[k]     <= div_step(up_h, up_den_h);
                r_dv_s[k]     <= div_step(up_s, up_den_s);
                r_dv_den_h[k] <= up_den_h;
                r_dv_den_s[k] <= up_den_s;
                r_dv_sum[k]   <= up_sum;
            end
        end
    end

    // ---------------- output ----------------
    assign o_m_axis_tvalid = r_dv_vld[DIV_STG-1];
    assign o_m_axis_tdata  = {r_dv_sum[DIV_STG-1],
                              r_dv_s[DIV_STG-1].quo,
                              r_dv_h[DIV_STG-1].quo[HUE_W-1:0]};

endmodule

// ===== hw/rtl/rhc_checker.sv =====
// ----------------------------------------------------------------------------
// rhc_checker
// Port-level assertions for rgb_to_hsl_convert_unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb_to_hsl_convert_unit_defines.svh"

module rhc_checker
    import rhc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    input  logic             o_s_axis_tready,
    input  logic [IN_W-1:0]  i_s_axis_tdata,   // red, green, blue
    input  logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    input  logic [OUT_W-1:0] o_m_axis_tdata    // hue, sat, sum
);

    logic             in_beat;
    logic             bw_px;
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [SUM_W-1:0] sum;

    assign in_beat = i_s_axis_tvalid && o_s_axis_tready;
    assign hue     = o_m_axis_tdata[14:0];
    assign sat     = o_m_axis_tdata[30:15];
    assign sum     = o_m_axis_tdata[39:31];
    assign bw_px   = o_m_axis_tvalid && (sum == '0 || sum == SUM_WHITE);

    // stalled result beat holds
    `RHC_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "output beat changed while stalled")

    // empty output stage means the whole pipe can take a beat
    `RHC_ASSERT_NOW(a_in_ready, !o_m_axis_tvalid, o_s_axis_tready, "input not ready with empty output")

    // hue stays below 360 degrees
    `RHC_ASSERT_NOW(a_hue_range, o_m_axis_tvalid, hue < HUE_LIMIT, "hue out of range")

    // black or white pixel carries no hue and no saturation
    `RHC_ASSERT_NOW(a_black_white, bw_px, hue == '0 && sat == '0, "hue or sat set for black or white")

    // accepted pixel carries known data
    `RHC_ASSERT_NOW(a_in_known, in_beat, !$isunknown(i_s_axis_tdata), "unknown pixel on input beat")

endmodule

bind rgb_to_hsl_convert_unit rhc_checker u_rhc_checker (.*);

// ===== dv/rgb_to_hsl_convert_unit_tb.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsl_convert_unit_tb
// Self-checking bench for the RGB to HSL pixel converter.
// ----------------------------------------------------------------------------
// Pixel beats go into the slave stream. For each accepted beat the bench works
// out hue, saturation and lightness sum in exact integer math and queues them.
// Every output beat is compared, field by field, with the oldest queued pixel.
// Tests: directed corners (grey, black, white, primaries, tied maxima, wrap of
// the red sector, the darkest and lightest colored pixels), uniform random
// pixels, corner-weighted random pixels, back-to-back streaming with no gaps,
// and a long receiver hold that fills the pipe and stalls the input.
// ----------------------------------------------------------------------------
module rgb_to_hsl_convert_unit_tb;
    import rhc_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int LIMIT_CYC   = 400000;
    localparam int DRAIN_CYC   = 20;      // settle time after the last result, with margin
    localparam int HOLD_CYC    = 40;      // long enough to fill all stages
    // hue scale: 60 deg = 3840 units, sector offsets, full circle
    localparam int HUE_SECTOR  = 3840;
    localparam int HUE_OFS_G   = 7680;
    localparam int HUE_OFS_B   = 15360;
    localparam int HUE_FULL    = 23040;
    localparam int SAT_FULL    = 65535;
    localparam int COMP_MAX    = 255;

    // one result, packed like the output tdata (hue in the low bits)
    typedef struct packed {
        logic [SUM_W-1:0] lsum;
        logic [SAT_W-1:0] sat;
        logic [HUE_W-1:0] hue;
    } t_hsl;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_valid = 1'b0;
    logic [IN_W-1:0]   s_data  = '0;
    logic              m_ready = 1'b0;
    logic              s_ready;
    logic              m_valid;
    logic [OUT_W-1:0]  m_data;

    t_hsl  hsl_expected[$];
    t_hsl  got_px, want_px;
    int    errors   = 0;
    bit    idle_on  = 1'b1;   // random gaps on both sides
    int    hold_req = 0;      // long receiver hold, in cycles
    int    rx_wait  = 0;

    rgb_to_hsl_convert_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),    // red[7:0], green[15:8], blue[23:16]
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)     // hue[14:0], sat[30:15], sum[39:31]
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Expected HSL of one pixel, exact rationals rounded to nearest, ties up
    // ------------------------------------------------------------------------
    function automatic t_hsl hsl_predict(input logic [7:0] r, g, b);
        t_hsl    px;
        int      ri, gi, bi, mx, mn, chroma, lsum, num, den;
        t_sector sec;
        ri = int'(r);
        gi = int'(g);
        bi = int'(b);
        mx = ri;
        mn = ri;
        if (gi > mx) mx = gi;
        if (bi > mx) mx = bi;
        if (gi < mn) mn = gi;
        if (bi < mn) mn = bi;
        chroma  = mx - mn;
        lsum    = mx + mn;
        px      = '0;
        px.lsum = lsum[SUM_W-1:0];
        if (chroma != 0) begin
            // red wins ties, then green
            if (mx == ri)      sec = SEC_RED;
            else if (mx == gi) sec = SEC_GREEN;
            else               sec = SEC_BLUE;
            case (sec)
                SEC_RED: begin
                    num = HUE_SECTOR * (gi - bi);
                    if (num < 0) num += HUE_FULL * chroma;   // wrap below 0 deg
                end
                SEC_GREEN: num = HUE_SECTOR * (bi - ri) + HUE_OFS_G * chroma;
                default:   num = HUE_SECTOR * (ri - gi) + HUE_OFS_B * chroma;
            endcase
            px.hue = HUE_W'((2 * num + chroma) / (2 * chroma));
            // divisor is the distance of the sum from the nearer end
            den    = (lsum <= COMP_MAX) ? lsum : 2 * COMP_MAX - lsum;
            px.sat = SAT_W'((2 * SAT_FULL * chroma + den) / (2 * den));
        end
        return px;
    endfunction

    // mostly no gap, some short ones, a few long ones
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 75) return 0;
        if (pick < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold counted here when requested
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_req != 0) begin
                rx_wait  = hold_req;
                hold_req = 0;
            end
            if (rx_wait == 0 && idle_on) rx_wait = gap_len();
            if (rx_wait > 0) begin
                m_ready <= 1'b0;
                rx_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Beat monitor: check output beats, queue predictions for input beats.
    // Each result passes through all the pipeline registers, so an input beat
    // never meets its own result at the same edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_valid && m_ready) begin
                got_px = m_data;
                if (hsl_expected.size() == 0) begin
                    $error("output beat with no pixel pending: %h", m_data);
                    errors++;
                end else begin
                    want_px = hsl_expected.pop_front();
                    if (got_px.hue != want_px.hue) begin
                        $error("hue: expected %0d, got %0d", want_px.hue, got_px.hue);
                        errors++;
                    end
                    if (got_px.sat != want_px.sat) begin
                        $error("saturation: expected %0d, got %0d",
                               want_px.sat, got_px.sat);
                        errors++;
                    end
                    if (got_px.lsum != want_px.lsum) begin
                        $error("lightness_sum: expected %0d, got %0d",
                               want_px.lsum, got_px.lsum);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready)
                hsl_expected.push_back(hsl_predict(s_data[7:0], s_data[15:8],
                                                   s_data[23:16]));
        end
    end

    // ------------------------------------------------------------------------
    // Sender: one pixel beat, then an optional gap
    // ------------------------------------------------------------------------
    task automatic send_pixel(input logic [7:0] r, g, b);
        int gap;
        s_valid <= 1'b1;
        s_data  <= {b, g, r};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        gap = idle_on ? gap_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            s_data  <= IN_W'($urandom);   // junk while idle
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // drop valid, wait for all results, then let the pipe settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (hsl_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic send_random_pixel();
        send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
    endtask

    // near-grey, tied maxima, or components from the range ends
    task automatic send_corner_pixel();
        logic [7:0] c[3];
        int         base, mode;
        mode = $urandom_range(0, 2);
        base = $urandom_range(0, 255);
        for (int k = 0; k < 3; k++) begin
            case (mode)
                0: begin
                    c[k] = 8'(base + $urandom_range(0, 4) - 2);
                    if (base < 2)   c[k] = 8'($urandom_range(0, 3));
                    if (base > 253) c[k] = 8'($urandom_range(252, 255));
                end
                1: c[k] = 8'(base);
                default: begin
                    case ($urandom_range(0, 3))
                        0: c[k] = 8'd0;
                        1: c[k] = 8'd1;
                        2: c[k] = 8'd254;
                        default: c[k] = 8'd255;
                    endcase
                end
            endcase
        end
        // ties: make one component differ, above or below the shared value
        if (mode == 1) c[2'($urandom_range(0, 2))] = 8'($urandom_range(0, 255));
        send_pixel(c[0], c[1], c[2]);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        idle_on = 1'b1;
        send_pixel(8'd0,   8'd0,   8'd0);     // black
        send_pixel(8'd255, 8'd255, 8'd255);   // white
        send_pixel(8'd128, 8'd128, 8'd128);   // grey
        send_pixel(8'd255, 8'd0,   8'd0);     // primaries
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);     // red/green tie, red wins
        send_pixel(8'd0,   8'd255, 8'd255);   // green/blue tie, green wins
        send_pixel(8'd255, 8'd0,   8'd255);   // red/blue tie, red wins
        send_pixel(8'd255, 8'd0,   8'd1);     // red sector, hue wraps
        send_pixel(8'd200, 8'd10,  8'd199);   // wrap, just above 300 deg
        send_pixel(8'd1,   8'd0,   8'd0);     // darkest colored pixel
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd255, 8'd255, 8'd254);   // lightest colored pixel
        send_pixel(8'd254, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd127, 8'd127);   // sum at the midpoint
        send_pixel(8'd127, 8'd128, 8'd128);   // sum at the midpoint too
        send_pixel(8'd3,   8'd1,   8'd2);     // saturation rounding tie
        send_pixel(8'd170, 8'd85,  8'd0);
        send_pixel(8'd0,   8'd85,  8'd170);
        drain();
    endtask

    task automatic test_random_pixels();
        idle_on = 1'b1;
        repeat (220) send_random_pixel();
        drain();
    endtask

    task automatic test_corner_pixels();
        idle_on = 1'b1;
        repeat (100) send_corner_pixel();
        drain();
    endtask

    // full rate: no gaps on either side
    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (80) send_random_pixel();
        drain();
    endtask

    // receiver holds off while pixels keep coming: pipe fills, input stalls
    task automatic test_output_hold();
        idle_on  = 1'b0;
        hold_req = HOLD_CYC;
        repeat (30) send_random_pixel();
        idle_on  = 1'b1;
        hold_req = HOLD_CYC / 2;
        repeat (20) send_corner_pixel();
        drain();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_pixels();
        test_corner_pixels();
        test_back_to_back();
        test_output_hold();
        if (hsl_expected.size() != 0) begin
            $error("%0d pixels never came out", hsl_expected.size());
            errors++;
        end
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #(2 * CLK_HALF * LIMIT_CYC);
        $display("status: fail");
        $finish;
    end

endmodule
